/* rtl/core/icpu_pkg.sv */
`default_nettype none

package icpu_pkg;

   localparam int CORE_WORDS_DEFAULT = 256;
   localparam int WORD_W             = 8;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_EXECUTE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam int BIT_D = 7;
   localparam int BIT_P = 6;
   localparam int BIT_G = 5;
   localparam int BIT_I = 4;

   localparam logic [3:0] FN_ADD   = 4'h0;
   localparam logic [3:0] FN_CALL  = 4'h1;
   localparam logic [3:0] FN_JMP   = 4'h2;
   localparam logic [3:0] FN_JMPT  = 4'h3;
   localparam logic [3:0] FN_JMPF  = 4'h4;
   localparam logic [3:0] FN_LOAD  = 4'h5;
   localparam logic [3:0] FN_STORE = 4'h6;
   localparam logic [3:0] FN_EXOP  = 4'h7;

   typedef struct packed {
      logic [1:0]        operation;
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [WORD_W-1:0] program_counter;
      logic [WORD_W-1:0] accumulator;
      logic [WORD_W-1:0] aux_accumulator;
      logic [WORD_W-1:0] effective_address;
      logic [WORD_W-1:0] frame_pointer;
      logic              is_halted;
   } rsp_type;

   typedef enum logic [3:0] {
      STEP_IDLE      = 4'd0,
      STEP_WRITE     = 4'd1,
      STEP_READ      = 4'd2,
      STEP_FETCH     = 4'd3,
      STEP_DECODE    = 4'd4,
      STEP_OPERAND   = 4'd5,
      STEP_FORM      = 4'd6,
      STEP_INDIRECT  = 4'd7,
      STEP_EXECUTE   = 4'd8,
      STEP_CALL2     = 4'd9,
      STEP_FINISH    = 4'd10
   } dp_step_type;

   typedef struct packed {
      logic        latch_req;
      dp_step_type step;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       halted;
      logic       direct;
      logic       indirect;
      logic       is_call;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/icpu_ctrl.sv */
`default_nettype none

module icpu_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  icpu_pkg::dp_status_type status,
   output icpu_pkg::dp_cmd_type    cmd
);
   import icpu_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_WRITE    = 11'b000_0000_0010,
      S_READ     = 11'b000_0000_0100,
      S_FETCH    = 11'b000_0000_1000,
      S_DECODE   = 11'b000_0001_0000,
      S_OPERAND  = 11'b000_0010_0000,
      S_FORM     = 11'b000_0100_0000,
      S_INDIRECT = 11'b000_1000_0000,
      S_EXECUTE  = 11'b001_0000_0000,
      S_CALL2    = 11'b010_0000_0000,
      S_FINISH   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign load_rsp  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      cmd.latch_req = accept;
      cmd.load_rsp  = load_rsp;
      cmd.step      = STEP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (status.req_op == OP_WRITE) begin
                  state_in = S_WRITE;
               end else if (status.req_op == OP_READ) begin
                  state_in = S_READ;
               end else if (status.req_op == OP_EXECUTE && !status.halted) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_WRITE: begin
            cmd.step = STEP_WRITE;
            state_in = S_FINISH;
         end
         S_READ: begin
            cmd.step = STEP_READ;
            state_in = S_FINISH;
         end
         S_FETCH: begin
            cmd.step = STEP_FETCH;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.step = STEP_DECODE;
            state_in = status.direct ? S_OPERAND : S_FORM;
         end
         S_OPERAND: begin
            cmd.step = STEP_OPERAND;
            state_in = S_FORM;
         end
         S_FORM: begin
            cmd.step = STEP_FORM;
            state_in = status.indirect ? S_INDIRECT : S_EXECUTE;
         end
         S_INDIRECT: begin
            cmd.step = STEP_INDIRECT;
            state_in = S_EXECUTE;
         end
         S_EXECUTE: begin
            cmd.step = STEP_EXECUTE;
            state_in = status.is_call ? S_CALL2 : S_FINISH;
         end
         S_CALL2: begin
            cmd.step = STEP_CALL2;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.step = STEP_FINISH;
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/icpu_dp.sv */
`default_nettype none

module icpu_dp #(
   parameter int CORE_WORDS = icpu_pkg::CORE_WORDS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  icpu_pkg::req_type           req_data,
   output icpu_pkg::rsp_type           rsp_data,
   input  wire                         csr_write,
   input  wire [icpu_pkg::WORD_W-1:0]  csr_data,
   input  icpu_pkg::dp_cmd_type        cmd,
   output icpu_pkg::dp_status_type     status
);
   import icpu_pkg::*;

   localparam int ADDR_W = $clog2(CORE_WORDS);

   logic [WORD_W-1:0] core_mem_ff [CORE_WORDS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_hit_ff;

   logic [WORD_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_we;
   logic              mem_re;
   logic              mem_in_range;
   logic [ADDR_W-1:0] mem_idx;
   logic [WORD_W-1:0] rd_word;

   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [WORD_W-1:0] pc_ff, pc_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] aux_ff, aux_in;
   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] frame_ff, frame_in;
   logic              halt_ff, halt_in;
   logic [WORD_W-1:0] gbase_ff, gbase_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [WORD_W-1:0] opnd_ff, opnd_in;
   logic [WORD_W-1:0] g_add;
   logic [WORD_W-1:0] formed;
   logic [WORD_W-1:0] call_addr;
   logic [3:0]        fn;

   assign mem_in_range = ({1'b0, mem_addr} < (WORD_W + 1)'(CORE_WORDS));
   assign mem_idx      = mem_addr[ADDR_W-1:0];
   assign rd_word      = mem_hit_ff ? mem_rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we && mem_in_range) begin
         core_mem_ff[mem_idx] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= core_mem_ff[mem_idx];
         mem_hit_ff   <= mem_in_range;
      end
   end

   assign fn        = code_ff[3:0];
   assign call_addr = addr_ff + frame_ff;

   always_comb begin
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      aux_in    = aux_ff;
      addr_in   = addr_ff;
      frame_in  = frame_ff;
      halt_in   = halt_ff;
      code_in   = code_ff;
      opnd_in   = opnd_ff;
      mem_addr  = pc_ff;
      mem_wdata = acc_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      g_add     = code_ff[BIT_G] ? gbase_ff : '0;
      formed    = opnd_ff + (code_ff[BIT_P] ? frame_ff : '0) + g_add;
      unique case (cmd.step)
         STEP_IDLE, STEP_FINISH: begin
         end
         STEP_WRITE: begin
            mem_addr  = req_ff.address;
            mem_wdata = req_ff.data;
            mem_we    = 1'b1;
         end
         STEP_READ: begin
            mem_addr = req_ff.address;
            mem_re   = 1'b1;
         end
         STEP_FETCH: begin
            mem_addr = pc_ff;
            mem_re   = 1'b1;
            pc_in    = pc_ff + 8'd1;
         end
         STEP_DECODE: begin
            code_in = rd_word;
            if (rd_word[BIT_D]) begin
               mem_addr = pc_ff;
               mem_re   = 1'b1;
               pc_in    = pc_ff + 8'd1;
            end else begin
               opnd_in = pc_ff;
            end
         end
         STEP_OPERAND: begin
            opnd_in = rd_word;
         end
         STEP_FORM: begin
            addr_in  = formed;
            mem_addr = formed;
            mem_re   = code_ff[BIT_I];
         end
         STEP_INDIRECT: begin
            addr_in = rd_word;
         end
         STEP_EXECUTE: begin
            unique case (fn)
               FN_ADD: begin
                  acc_in = acc_ff + addr_ff;
               end
               FN_CALL: begin
                  addr_in   = call_addr;
                  mem_addr  = call_addr;
                  mem_wdata = frame_ff;
                  mem_we    = 1'b1;
               end
               FN_JMP: begin
                  pc_in = addr_ff;
               end
               FN_JMPT: begin
                  if (acc_ff != '0) begin
                     pc_in = addr_ff;
                  end
               end
               FN_JMPF: begin
                  if (acc_ff == '0) begin
                     pc_in = addr_ff;
                  end
               end
               FN_LOAD: begin
                  aux_in = acc_ff;
                  acc_in = addr_ff;
               end
               FN_STORE: begin
                  mem_addr  = addr_ff;
                  mem_wdata = acc_ff;
                  mem_we    = 1'b1;
               end
               FN_EXOP: begin
               end
               default: begin
                  halt_in = 1'b1;
               end
            endcase
         end
         STEP_CALL2: begin
            mem_addr  = addr_ff + 8'd1;
            mem_wdata = pc_ff;
            mem_we    = 1'b1;
            frame_in  = addr_ff;
            pc_in     = acc_ff;
         end
         default: begin
         end
      endcase
   end

   assign gbase_in = csr_write ? csr_data : gbase_ff;

   always_comb begin
      rsp_in.read_data         = (req_ff.operation == OP_READ) ? rd_word : '0;
      rsp_in.program_counter   = pc_ff;
      rsp_in.accumulator       = acc_ff;
      rsp_in.aux_accumulator   = aux_ff;
      rsp_in.effective_address = addr_ff;
      rsp_in.frame_pointer     = frame_ff;
      rsp_in.is_halted         = halt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         acc_ff   <= '0;
         aux_ff   <= '0;
         addr_ff  <= '0;
         frame_ff <= '0;
         halt_ff  <= 1'b0;
         gbase_ff <= '0;
      end else begin
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         aux_ff   <= aux_in;
         addr_ff  <= addr_in;
         frame_ff <= frame_in;
         halt_ff  <= halt_in;
         gbase_ff <= gbase_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      opnd_ff <= opnd_in;
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   assign status.req_op   = req_data.operation;
   assign status.halted   = halt_ff;
   assign status.direct   = rd_word[BIT_D];
   assign status.indirect = code_ff[BIT_I];
   assign status.is_call  = (fn == FN_CALL);

endmodule

`default_nettype wire

/* rtl/core/intcode_style_cpu_step_top.sv */
`default_nettype none

// Small 8-bit accumulator processor with a core of CORE_WORDS words behind a single
// memory port with a registered read. Each request transaction writes a core word, reads
// a core word or executes one instruction, and yields exactly one response transaction
// carrying the register file after it. The block handles one transaction at a time: a
// write or read passes its own step, then the finish step that loads its response; an
// instruction passes fetch, decode, an operand step for an operand word, form, an
// indirect step for indirection, execute, a second call step for a call's second store,
// and finish, set by the dependent core accesses through the one memory port; an unused
// operation code or an instruction on a halted machine goes straight to finish. A
// response that is still waiting holds the next transaction in its last step until the
// response is taken. A request is accepted while the previous response still waits. The
// user must write the global base register through the csr port only while the block is
// idle; the block does not enforce it. Core words must be written before they are read.
module intcode_style_cpu_step_top #(
   parameter int CORE_WORDS = icpu_pkg::CORE_WORDS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  icpu_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output icpu_pkg::rsp_type           rsp_data,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [icpu_pkg::WORD_W-1:0]  csr_data
);
   import icpu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   icpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   icpu_dp #(
      .CORE_WORDS (CORE_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Request accepted while a transaction was in flight.");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("Loaded response not presented.");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("Halt flag cleared without reset.");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("Response overwritten before it was taken.");

endmodule

`default_nettype wire
